### hw/rtl/trifs_pkg.sv
package trifs_pkg;

    localparam int unsigned NUM_CHAN   = 4;
    localparam int unsigned NUM_VERT   = 3;
    localparam int unsigned QUO_BITS   = 8;
    localparam logic [7:0]  CHAN_MAX   = 8'hFF;
    localparam logic [15:0] DIV255_MUL = 16'h8081;
    localparam int unsigned DIV255_SH  = 23;

    typedef logic [7:0] t_chan;
    typedef logic [NUM_CHAN-1:0][7:0] t_rgba;

    function automatic t_chan chan_of(input logic [31:0] c, input int unsigned k);
        return c[8*k +: 8];
    endfunction

endpackage

### hw/rtl/triangle_fragment_shade_blend_core.sv
// Shades one fragment of a colour-interpolated triangle per beat: edge functions
// decide coverage (edges count as inside, zero-area triangles cover nothing), the
// vertex colours are interpolated barycentrically and blended over the
// destination by the interpolated alpha; uncovered beats return the destination.
// Fully pipelined: one beat per cycle while the output is not stalled, through 5
// setup stages, 10 for the weighted sums and the 8-stage restoring divider and 3
// blend stages. Bubbles are squeezed out while the output is stalled.
module triangle_fragment_shade_blend_core
    import trifs_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by_coord,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic [31:0]                  i_color_a,
    input  logic [31:0]                  i_color_b,
    input  logic [31:0]                  i_color_c,
    input  logic [10:0]                  i_pixel_x,
    input  logic [10:0]                  i_pixel_y,
    input  logic [31:0]                  i_dest_color,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_covered,
    output logic [31:0]                  o_result_color
);

    localparam int DW = ((COORD_BITS > 12) ? COORD_BITS : 12) + 1;
    localparam int UW = 2 * DW + 3;

    logic          s_valid, s_stall, s_inside;
    logic [UW-1:0] s_det, s_u1, s_u2, s_u3;
    logic [31:0]   s_ca, s_cb, s_cc, s_dst;

    logic          m_valid, m_stall, m_inside;
    t_rgba         m_src;
    logic [31:0]   m_dst;

    trifs_setup #(.CW(COORD_BITS)) u_setup (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_ax         (i_ax),
        .i_ay         (i_ay),
        .i_bx         (i_bx),
        .i_by_coord   (i_by_coord),
        .i_cx         (i_cx),
        .i_cy         (i_cy),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_color_a    (i_color_a),
        .i_color_b    (i_color_b),
        .i_color_c    (i_color_c),
        .i_dest_color (i_dest_color),
        .o_valid      (s_valid),
        .i_stall      (s_stall),
        .o_inside     (s_inside),
        .o_det        (s_det),
        .o_u1         (s_u1),
        .o_u2         (s_u2),
        .o_u3         (s_u3),
        .o_color_a    (s_ca),
        .o_color_b    (s_cb),
        .o_color_c    (s_cc),
        .o_dest_color (s_dst)
    );

    trifs_interp #(.UW(UW)) u_interp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_valid),
        .o_stall      (s_stall),
        .i_inside     (s_inside),
        .i_det        (s_det),
        .i_u1         (s_u1),
        .i_u2         (s_u2),
        .i_u3         (s_u3),
        .i_color_a    (s_ca),
        .i_color_b    (s_cb),
        .i_color_c    (s_cc),
        .i_dest_color (s_dst),
        .o_valid      (m_valid),
        .i_stall      (m_stall),
        .o_inside     (m_inside),
        .o_src        (m_src),
        .o_dest_color (m_dst)
    );

    trifs_blend u_blend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (m_valid),
        .o_stall        (m_stall),
        .i_inside       (m_inside),
        .i_src          (m_src),
        .i_dest_color   (m_dst),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_covered      (o_covered),
        .o_result_color (o_result_color)
    );

    a_setup_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_valid && s_stall |=> s_valid)
        else $error("setup beat dropped while stalled");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall && s_valid && m_valid)
        else $error("input stalled without a full pipeline");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

### hw/rtl/trifs_setup.sv
module trifs_setup
    import trifs_pkg::*;
#(
    parameter int CW = 12,
    localparam int DW = ((CW > 12) ? CW : 12) + 1,
    localparam int PW = 2 * DW,
    localparam int UW = PW + 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [CW-1:0] i_ax,
    input  logic signed [CW-1:0] i_ay,
    input  logic signed [CW-1:0] i_bx,
    input  logic signed [CW-1:0] i_by_coord,
    input  logic signed [CW-1:0] i_cx,
    input  logic signed [CW-1:0] i_cy,
    input  logic [10:0]          i_pixel_x,
    input  logic [10:0]          i_pixel_y,
    input  logic [31:0]          i_color_a,
    input  logic [31:0]          i_color_b,
    input  logic [31:0]          i_color_c,
    input  logic [31:0]          i_dest_color,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_inside,
    output logic [UW-1:0]        o_det,
    output logic [UW-1:0]        o_u1,
    output logic [UW-1:0]        o_u2,
    output logic [UW-1:0]        o_u3,
    output logic [31:0]          o_color_a,
    output logic [31:0]          o_color_b,
    output logic [31:0]          o_color_c,
    output logic [31:0]          o_dest_color
);

    localparam int N = 5;

    logic [N-1:0] r_v;
    logic [N:0]   en;
    logic [31:0]  r_cd [0:N-1][0:3];

    logic signed [DW-1:0] r_xbc, r_ybc, r_xca, r_yca, r_xcp, r_ycp;
    logic signed [PW-1:0] r_pd1, r_pd2, r_pa1, r_pb1, r_pa2, r_pb2;
    logic signed [PW:0]   r3_det, r3_u1, r3_u2;
    logic signed [UW-1:0] r4_det, r4_u1, r4_u2, r4_u3;
    logic                 r5_in;
    logic [UW-1:0]        r5_det, r5_u1, r5_u2, r5_u3;

    logic                 n_in, n_neg;

    always_comb begin
        en[N] = !i_stall;
        for (int k = N - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < N; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_comb begin
        n_neg = r4_det[UW-1];
        n_in  = (r4_det != '0)
             && ((r4_u1 == '0) || (r4_u1[UW-1] == n_neg))
             && ((r4_u2 == '0) || (r4_u2[UW-1] == n_neg))
             && ((r4_u3 == '0) || (r4_u3[UW-1] == n_neg));
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_cd[0][0] <= i_color_a;
            r_cd[0][1] <= i_color_b;
            r_cd[0][2] <= i_color_c;
            r_cd[0][3] <= i_dest_color;
            r_xbc <= DW'(i_cx) - DW'(i_bx);
            r_ybc <= DW'(i_cy) - DW'(i_by_coord);
            r_xca <= DW'(i_ax) - DW'(i_cx);
            r_yca <= DW'(i_ay) - DW'(i_cy);
            r_xcp <= DW'($signed({1'b0, i_pixel_x})) - DW'(i_cx);
            r_ycp <= DW'($signed({1'b0, i_pixel_y})) - DW'(i_cy);
        end
        for (int k = 1; k < N; k++) begin
            if (en[k]) r_cd[k] <= r_cd[k-1];
        end
        if (en[1]) begin
            r_pd1 <= r_xbc * r_yca;
            r_pd2 <= r_xca * r_ybc;
            r_pa1 <= r_xbc * r_ycp;
            r_pb1 <= r_xcp * r_ybc;
            r_pa2 <= r_xca * r_ycp;
            r_pb2 <= r_xcp * r_yca;
        end
        if (en[2]) begin
            r3_det <= (PW+1)'(r_pd1) - (PW+1)'(r_pd2);
            r3_u1  <= (PW+1)'(r_pa1) - (PW+1)'(r_pb1);
            r3_u2  <= (PW+1)'(r_pa2) - (PW+1)'(r_pb2);
        end
        if (en[3]) begin
            r4_det <= UW'(r3_det);
            r4_u1  <= UW'(r3_u1);
            r4_u2  <= UW'(r3_u2);
            r4_u3  <= UW'(r3_det) - UW'(r3_u1) - UW'(r3_u2);
        end
        if (en[4]) begin
            r5_in  <= n_in;
            r5_det <= n_neg ? UW'(-r4_det) : UW'(r4_det);
            r5_u1  <= n_neg ? UW'(-r4_u1)  : UW'(r4_u1);
            r5_u2  <= n_neg ? UW'(-r4_u2)  : UW'(r4_u2);
            r5_u3  <= n_neg ? UW'(-r4_u3)  : UW'(r4_u3);
        end
    end

    assign o_stall      = !en[0];
    assign o_valid      = r_v[N-1];
    assign o_inside     = r5_in;
    assign o_det        = r5_det;
    assign o_u1         = r5_u1;
    assign o_u2         = r5_u2;
    assign o_u3         = r5_u3;
    assign o_color_a    = r_cd[N-1][0];
    assign o_color_b    = r_cd[N-1][1];
    assign o_color_c    = r_cd[N-1][2];
    assign o_dest_color = r_cd[N-1][3];

endmodule

### hw/rtl/trifs_interp.sv
module trifs_interp
    import trifs_pkg::*;
#(
    parameter int UW = 29,
    localparam int NW = UW + 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_inside,
    input  logic [UW-1:0] i_det,
    input  logic [UW-1:0] i_u1,
    input  logic [UW-1:0] i_u2,
    input  logic [UW-1:0] i_u3,
    input  logic [31:0]   i_color_a,
    input  logic [31:0]   i_color_b,
    input  logic [31:0]   i_color_c,
    input  logic [31:0]   i_dest_color,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_inside,
    output t_rgba         o_src,
    output logic [31:0]   o_dest_color
);

    localparam int N = QUO_BITS + 2;

    logic [N-1:0]    r_v;
    logic [N:0]      en;
    logic            r_in  [0:N-1];
    logic [UW-1:0]   r_det [0:N-1];
    logic [31:0]     r_dst [0:N-1];

    logic [UW+7:0]   r_p   [0:NUM_CHAN-1][0:NUM_VERT-1];
    logic [NW-1:0]   r_rem [0:QUO_BITS][0:NUM_CHAN-1];
    logic [7:0]      r_q   [0:QUO_BITS][0:NUM_CHAN-1];

    logic [NW-1:0]   n_rem [1:QUO_BITS][0:NUM_CHAN-1];
    logic [7:0]      n_q   [1:QUO_BITS][0:NUM_CHAN-1];

    always_comb begin
        en[N] = !i_stall;
        for (int k = N - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < N; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // restoring divide, one quotient bit per stage, msb first
    always_comb begin
        logic [NW-1:0] trial;
        for (int d = 1; d <= QUO_BITS; d++) begin
            trial = NW'(r_det[d]) << (QUO_BITS - d);
            for (int k = 0; k < NUM_CHAN; k++) begin
                if (r_rem[d-1][k] >= trial) begin
                    n_rem[d][k] = r_rem[d-1][k] - trial;
                    n_q[d][k]   = {r_q[d-1][k][6:0], 1'b1};
                end else begin
                    n_rem[d][k] = r_rem[d-1][k];
                    n_q[d][k]   = {r_q[d-1][k][6:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_in[0]  <= i_inside;
            r_det[0] <= i_det;
            r_dst[0] <= i_dest_color;
            for (int k = 0; k < NUM_CHAN; k++) begin
                r_p[k][0] <= chan_of(i_color_a, k) * i_u1;
                r_p[k][1] <= chan_of(i_color_b, k) * i_u2;
                r_p[k][2] <= chan_of(i_color_c, k) * i_u3;
            end
        end
        for (int s = 1; s < N; s++) begin
            if (en[s]) begin
                r_in[s]  <= r_in[s-1];
                r_det[s] <= r_det[s-1];
                r_dst[s] <= r_dst[s-1];
            end
        end
        if (en[1]) begin
            for (int k = 0; k < NUM_CHAN; k++) begin
                r_rem[0][k] <= NW'(r_p[k][0]) + NW'(r_p[k][1]) + NW'(r_p[k][2]);
                r_q[0][k]   <= '0;
            end
        end
        for (int d = 1; d <= QUO_BITS; d++) begin
            if (en[d+1]) begin
                r_rem[d] <= n_rem[d];
                r_q[d]   <= n_q[d];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_CHAN; k++) begin
            o_src[k] = r_q[QUO_BITS][k];
        end
    end

    assign o_stall      = !en[0];
    assign o_valid      = r_v[N-1];
    assign o_inside     = r_in[N-1];
    assign o_dest_color = r_dst[N-1];

endmodule

### hw/rtl/trifs_blend.sv
module trifs_blend
    import trifs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_inside,
    input  t_rgba       i_src,
    input  logic [31:0] i_dest_color,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_covered,
    output logic [31:0] o_result_color
);

    localparam int N = 3;

    logic [N-1:0] r_v;
    logic [N:0]   en;
    logic         r_in  [0:N-2];
    logic [31:0]  r_dst [0:N-2];
    logic [15:0]  r_m   [0:2];
    logic [31:0]  r_p   [0:2];
    logic         r_cov;
    logic [31:0]  r_res;
    logic [31:0]  n_res;

    always_comb begin
        en[N] = !i_stall;
        for (int k = N - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < N; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // x / 255 as (x * 0x8081) >> 23, exact for 16-bit x
    always_comb begin
        n_res = r_dst[1];
        if (r_in[1]) begin
            for (int k = 0; k < 3; k++) begin
                n_res[8*k +: 8] = r_p[k][DIV255_SH +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_in[0]  <= i_inside;
            r_dst[0] <= i_dest_color;
            for (int k = 0; k < 3; k++) begin
                r_m[k] <= 16'(chan_of(i_dest_color, k)) * 16'(CHAN_MAX - i_src[3])
                        + 16'(i_src[k]) * 16'(i_src[3]);
            end
        end
        if (en[1]) begin
            r_in[1]  <= r_in[0];
            r_dst[1] <= r_dst[0];
            for (int k = 0; k < 3; k++) begin
                r_p[k] <= 32'(r_m[k]) * 32'(DIV255_MUL);
            end
        end
        if (en[2]) begin
            r_cov <= r_in[1];
            r_res <= n_res;
        end
    end

    assign o_stall        = !en[0];
    assign o_valid        = r_v[N-1];
    assign o_covered      = r_cov;
    assign o_result_color = r_res;

endmodule
